/* src/ultrasonic_scan_and_proximity_buzzer_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic scan and proximity buzzer core
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_SCAN_AND_PROXIMITY_BUZZER_CORE_DEFINES_SVH
`define ULTRASONIC_SCAN_AND_PROXIMITY_BUZZER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define USBZ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define USBZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/usbz_pkg.sv */
// ----------------------------------------------------------------------------
// usbz_pkg
// Types and fixed constants shared by the ultrasonic scan and buzzer core.
// ----------------------------------------------------------------------------
package usbz_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_TICK_DIVIDER    = 3'd0,
		REG_WARN_DISTANCE   = 3'd1,
		REG_MAX_RANGE       = 3'd2,
		REG_BUZZ_PERIOD_MIN = 3'd3,
		REG_BUZZ_PERIOD_MAX = 3'd4
	} reg_index_t;

	localparam int CFG_DATA_W = 10;
	localparam int DIST_W     = 10;
	localparam int MAX_SENSORS = 3;

	// Reset values of the configuration registers.
	localparam logic [7:0] RST_TICK_DIVIDER    = 8'd5;
	localparam logic [9:0] RST_WARN_DISTANCE   = 10'd40;
	localparam logic [9:0] RST_MAX_RANGE       = 10'd380;
	localparam logic [3:0] RST_BUZZ_PERIOD_MIN = 4'd1;
	localparam logic [3:0] RST_BUZZ_PERIOD_MAX = 4'd4;

	// Echo time to centimeters: divide by 116 = 4 * 29. The quotient by 29
	// uses a reciprocal multiply, exact for dividends below 29 * 1024.
	localparam int ECHO_DIVISOR   = 116;
	localparam int ECHO_LIMIT     = ECHO_DIVISOR * 1024;
	localparam int DIV29_MUL      = 18079;
	localparam int DIV29_SHIFT    = 19;

	// Distance / 10 = (distance / 2) / 5, reciprocal exact for 9-bit values.
	localparam int DIV5_MUL   = 205;
	localparam int DIV5_SHIFT = 10;

	typedef struct packed {
		logic [7:0] tick_divider;
		logic [9:0] warn_distance;
		logic [9:0] max_range;
		logic [3:0] buzz_period_min;
		logic [3:0] buzz_period_max;
	} cfg_t;

	typedef struct packed {
		logic [3:0] count;
		logic       level;
	} buzz_state_t;

endpackage

/* src/ultrasonic_scan_and_proximity_buzzer_core.sv */
// ----------------------------------------------------------------------------
// ultrasonic_scan_and_proximity_buzzer_core
// Round-robin ultrasonic echo ranging with a distance-driven warning buzzer.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                Payload
// input     in_valid / in_ready      func, sensor, capture
// result    out_valid / out_ready    trigger, buzzer_on, dist_one..dist_three
// config    cfg_wen                  cfg_index, cfg_wdata
//
// The accepting edge loads a request into the input register, and the update
// step moves it through the update logic into the result register once that
// register is free or being emptied, so the result is registered. One request
// is accepted every cycle while the result side does not stall; the rate
// is set by the single state update that the tick counter, echo timers and buzzer
// share. arst_n clears the valid flags and block state and loads the register
// reset values; sensor one counts as fired. A stalled result holds the input
// register, which then stalls the input side only once both registers are full.
//
module ultrasonic_scan_and_proximity_buzzer_core #(
	parameter int NUM_SENSORS  = 3,
	parameter int CAPTURE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    func,
	input  logic [1:0]              sensor,
	input  logic [CAPTURE_BITS-1:0] capture,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              trigger,
	output logic                    buzzer_on,
	output logic [9:0]              dist_one,
	output logic [9:0]              dist_two,
	output logic [9:0]              dist_three,

	input  logic                    cfg_wen,
	input  logic [2:0]              cfg_index,
	input  logic [9:0]              cfg_wdata
);

`include "ultrasonic_scan_and_proximity_buzzer_core_defines.svh"

	localparam logic [1:0] NUM_S = 2'(NUM_SENSORS);

	// Configuration registers.
	usbz_pkg::cfg_t cfg_q;

	// Input register.
	logic                    valid_s1;
	logic                    func_s1;
	logic [1:0]              sensor_s1;
	logic [CAPTURE_BITS-1:0] capture_s1;

	// Result register.
	logic       valid_s2;
	logic [1:0] trigger_s2;
	logic       buzzer_s2;
	logic [9:0] dist_s2 [usbz_pkg::MAX_SENSORS];

	// Block state.
	logic [7:0]              tick_count_q;
	logic [1:0]              scan_index_q;
	logic [1:0]              armed_q;
	logic                    phase_q [usbz_pkg::MAX_SENSORS];
	logic [CAPTURE_BITS-1:0] start_q [usbz_pkg::MAX_SENSORS];
	logic [9:0]              dist_q  [usbz_pkg::MAX_SENSORS];
	usbz_pkg::buzz_state_t   buzz_q;

	// Next state.
	logic [7:0]              tick_count_d;
	logic [1:0]              scan_index_d;
	logic [1:0]              armed_d;
	logic                    phase_d [usbz_pkg::MAX_SENSORS];
	logic [CAPTURE_BITS-1:0] start_d [usbz_pkg::MAX_SENSORS];
	logic [9:0]              dist_d  [usbz_pkg::MAX_SENSORS];
	usbz_pkg::buzz_state_t   buzz_d;
	usbz_pkg::buzz_state_t   buzz_fire;

	logic       advance;
	logic       fire;
	logic [1:0] trig_d;
	logic [7:0] tick_inc;
	logic [1:0] scan_next;
	logic [1:0] rd_idx;
	logic       edge_ok;
	logic [9:0] range_dist;
	logic       range_ok;

	// The update step runs whenever the input register holds a request and
	// the result register is free or being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_divider    <= usbz_pkg::RST_TICK_DIVIDER;
			cfg_q.warn_distance   <= usbz_pkg::RST_WARN_DISTANCE;
			cfg_q.max_range       <= usbz_pkg::RST_MAX_RANGE;
			cfg_q.buzz_period_min <= usbz_pkg::RST_BUZZ_PERIOD_MIN;
			cfg_q.buzz_period_max <= usbz_pkg::RST_BUZZ_PERIOD_MAX;
		end else if (cfg_wen) begin
			case (cfg_index)
				usbz_pkg::REG_TICK_DIVIDER:    cfg_q.tick_divider    <= cfg_wdata[7:0];
				usbz_pkg::REG_WARN_DISTANCE:   cfg_q.warn_distance   <= cfg_wdata;
				usbz_pkg::REG_MAX_RANGE:       cfg_q.max_range       <= cfg_wdata;
				usbz_pkg::REG_BUZZ_PERIOD_MIN: cfg_q.buzz_period_min <= cfg_wdata[3:0];
				usbz_pkg::REG_BUZZ_PERIOD_MAX: cfg_q.buzz_period_max <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			sensor_s1  <= sensor;
			capture_s1 <= capture;
		end
	end

	// Sensor code three has no timer slot; point the read at slot zero, the
	// edge is rejected anyway.
	assign rd_idx = (sensor_s1 == 2'd3) ? 2'd0 : sensor_s1;

	usbz_range #(
		.CAPTURE_BITS(CAPTURE_BITS)
	) u_range (
		.capture   (capture_s1),
		.start_time(start_q[rd_idx]),
		.max_range (cfg_q.max_range),
		.dist_cm   (range_dist),
		.accept    (range_ok)
	);

	usbz_buzz u_buzz (
		.dist_cm(dist_q[0]),
		.cfg    (cfg_q),
		.cur    (buzz_q),
		.nxt    (buzz_fire)
	);

	assign tick_inc  = tick_count_q + 8'd1;
	// Round robin 1, 2, ... NUM_SENSORS, then back to sensor one.
	assign scan_next = (scan_index_q >= NUM_S) ? 2'd1 : scan_index_q + 2'd1;
	// An edge counts only from an existing sensor that is the one armed.
	assign edge_ok   = (sensor_s1 < NUM_S) && (sensor_s1 != 2'd3) &&
		(armed_q == sensor_s1 + 2'd1);

	always_comb begin
		tick_count_d = tick_count_q;
		scan_index_d = scan_index_q;
		armed_d      = armed_q;
		phase_d      = phase_q;
		start_d      = start_q;
		dist_d       = dist_q;
		buzz_d       = buzz_q;
		fire         = 1'b0;
		trig_d       = 2'd0;
		if (advance) begin
			if (!func_s1) begin
				// A divider of zero never holds the count back, so it fires on
				// every tick just as a divider of one does.
				if (tick_inc < cfg_q.tick_divider) begin
					tick_count_d = tick_inc;
				end else begin
					fire         = 1'b1;
					tick_count_d = 8'd0;
					scan_index_d = scan_next;
					armed_d      = scan_next;
					trig_d       = scan_next;
					buzz_d       = buzz_fire;
				end
			end else if (edge_ok) begin
				if (!phase_q[rd_idx]) begin
					// First edge: remember when the echo pulse started.
					start_d[rd_idx] = capture_s1;
					phase_d[rd_idx] = 1'b1;
				end else begin
					// The closing edge ends the measurement and disarms the sensor;
					// an out-of-range result keeps the old distance.
					if (range_ok) begin
						dist_d[rd_idx] = range_dist;
					end
					phase_d[rd_idx] = 1'b0;
					armed_d         = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= 8'd0;
			scan_index_q <= 2'd1;
			armed_q      <= 2'd1;
			buzz_q       <= '0;
			for (int i = 0; i < usbz_pkg::MAX_SENSORS; i++) begin
				phase_q[i] <= 1'b0;
				start_q[i] <= '0;
				dist_q[i]  <= '0;
			end
		end else begin
			tick_count_q <= tick_count_d;
			scan_index_q <= scan_index_d;
			armed_q      <= armed_d;
			buzz_q       <= buzz_d;
			phase_q      <= phase_d;
			start_q      <= start_d;
			dist_q       <= dist_d;
		end
	end

	// Result register: filled on each update step, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			trigger_s2 <= trig_d;
			buzzer_s2  <= buzz_d.level;
			dist_s2    <= dist_d;
		end
	end

	assign out_valid  = valid_s2;
	assign trigger    = trigger_s2;
	assign buzzer_on  = buzzer_s2;
	assign dist_one   = dist_s2[0];
	assign dist_two   = dist_s2[1];
	assign dist_three = dist_s2[2];

	`USBZ_ASSERT_NEXT(a_step_gives_result, advance, valid_s2, "update step left no result")
	`USBZ_ASSERT_NEXT(a_fire_clears_count, fire, tick_count_q == 8'd0, "fire kept tick count")
	`USBZ_ASSERT_NOW(a_armed_in_range, 1'b1, armed_q <= NUM_S, "armed sensor out of range")
	`USBZ_ASSERT_NOW(a_stall_only_full, !in_ready, valid_s1 && valid_s2, "stall with free slot")

endmodule

/* src/usbz_range.sv */
// ----------------------------------------------------------------------------
// usbz_range
// Converts a wrapped echo time difference into a distance and range check.
// ----------------------------------------------------------------------------
module usbz_range #(
	parameter int CAPTURE_BITS = 16
) (
	input  logic [CAPTURE_BITS-1:0] capture,
	input  logic [CAPTURE_BITS-1:0] start_time,
	input  logic [9:0]              max_range,
	output logic [9:0]              dist_cm,
	output logic                    accept
);

	localparam int EXT_W = (CAPTURE_BITS > 17) ? CAPTURE_BITS : 17;

	logic [CAPTURE_BITS-1:0] diff;
	logic [EXT_W-1:0]        diff_ext;
	logic                    too_far;
	logic [14:0]             quarter;
	logic [29:0]             product;

	assign diff     = capture - start_time;
	assign diff_ext = EXT_W'(diff);

	// Anything at or above 116 * 1024 cannot fit a 10-bit range setting.
	assign too_far  = diff_ext >= EXT_W'(usbz_pkg::ECHO_LIMIT);
	assign quarter  = diff_ext[16:2];
	assign product  = 30'(quarter) * 30'(usbz_pkg::DIV29_MUL);
	assign dist_cm  = product[usbz_pkg::DIV29_SHIFT +: 10];
	assign accept   = !too_far && (dist_cm <= max_range);

endmodule

/* src/usbz_buzz.sv */
// ----------------------------------------------------------------------------
// usbz_buzz
// Next buzzer counter and level for one scan interval.
// ----------------------------------------------------------------------------
module usbz_buzz (
	input  logic [9:0]           dist_cm,
	input  usbz_pkg::cfg_t       cfg,
	input  usbz_pkg::buzz_state_t cur,
	output usbz_pkg::buzz_state_t nxt
);

	logic [8:0]  half;
	logic [16:0] product;
	logic [6:0]  quot;
	logic [6:0]  period_raw;
	logic [6:0]  period_lo;
	logic [6:0]  period_cl;
	logic [3:0]  period;
	logic [3:0]  count_inc;

	assign half       = dist_cm[9:1];
	assign product    = 17'(half) * 17'(usbz_pkg::DIV5_MUL);
	assign quot       = product[usbz_pkg::DIV5_SHIFT +: 7];
	assign period_raw = quot + 7'd1;

	// The upper clamp is applied last, so it wins when the clamps cross.
	assign period_lo  = (period_raw <= {3'b000, cfg.buzz_period_min}) ?
		{3'b000, cfg.buzz_period_min} : period_raw;
	assign period_cl  = (period_lo >= {3'b000, cfg.buzz_period_max}) ?
		{3'b000, cfg.buzz_period_max} : period_lo;
	assign period     = period_cl[3:0];
	assign count_inc  = cur.count + 4'd1;

	always_comb begin
		nxt = cur;
		if (dist_cm > cfg.warn_distance) begin
			nxt.level = 1'b0;
		end else if (count_inc >= period) begin
			nxt.level = !cur.level;
			nxt.count = 4'd0;
		end else begin
			nxt.count = count_inc;
		end
	end

endmodule

/* test/usbz_range_checker.sv */
// ----------------------------------------------------------------------------
// usbz_range_checker
// Watches the request, result and register-write ports of the ultrasonic scan
// core. It keeps its own copy of the scan, echo-timing and buzzer state, works
// out the result of every accepted request and compares each result that
// leaves the core against the oldest outstanding one.
// ----------------------------------------------------------------------------
module usbz_range_checker #(
	parameter int NUM_SENSORS = 3
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [1:0]  sensor,
	input  logic [15:0] capture,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  trigger,
	input  logic        buzzer_on,
	input  logic [9:0]  dist_one,
	input  logic [9:0]  dist_two,
	input  logic [9:0]  dist_three,

	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_wdata,

	output int          mismatches,
	output int          waiting,
	output int          results_seen,
	output int          fires_seen,
	output int          readings_seen
);

	localparam int         ECHO_TICKS_PER_CM = 116;
	localparam int         REPORT_LIMIT      = 10;
	localparam logic [1:0] NO_TRIGGER        = 2'd0;

	typedef struct packed {
		logic [1:0] trigger;
		logic       buzzer;
		logic [9:0] dist_one;
		logic [9:0] dist_two;
		logic [9:0] dist_three;
	} scan_result_t;

	usbz_pkg::cfg_t settings;
	logic [7:0]   tick_cnt;
	logic [1:0]   scan_sel;
	logic [1:0]   armed;
	logic [2:0]   half_done;
	logic [15:0]  echo_start [3];
	logic [9:0]   range_cm [3];
	logic [3:0]   beep_cnt;
	logic         beep_level;
	scan_result_t outstanding_q [$];

	// The buzzer period follows sensor one; out of the warning zone the
	// buzzer is silenced but its count is left alone.
	function void refresh_buzzer();
		int period;
		if (range_cm[0] > settings.warn_distance) begin
			beep_level = 1'b0;
			return;
		end
		period = range_cm[0] / 10 + 1;
		if (period <= settings.buzz_period_min) period = settings.buzz_period_min;
		if (period >= settings.buzz_period_max) period = settings.buzz_period_max;
		beep_cnt = beep_cnt + 4'd1;
		if (beep_cnt >= period) begin
			beep_level = ~beep_level;
			beep_cnt   = '0;
		end
	endfunction

	function logic [1:0] advance_tick();
		tick_cnt = tick_cnt + 8'd1;
		if (tick_cnt < settings.tick_divider) return NO_TRIGGER;
		tick_cnt = '0;
		if (scan_sel >= NUM_SENSORS) scan_sel = 2'd1;
		else scan_sel = scan_sel + 2'd1;
		armed = scan_sel;
		refresh_buzzer();
		return scan_sel;
	endfunction

	function void take_edge(input logic [1:0] src, input logic [15:0] stamp);
		logic [15:0] span;
		int          cm;
		if (src >= NUM_SENSORS) return;
		if (armed != src + 2'd1) return;
		if (!half_done[src]) begin
			echo_start[src] = stamp;
			half_done[src]  = 1'b1;
			return;
		end
		span = stamp - echo_start[src];
		cm   = span / ECHO_TICKS_PER_CM;
		if (cm <= settings.max_range) begin
			range_cm[src] = cm[9:0];
			readings_seen++;
		end
		half_done[src] = 1'b0;
		armed          = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_result_t got;
		scan_result_t want;
		logic [1:0]   fired;
		if (!arst_n) begin
			settings.tick_divider    = usbz_pkg::RST_TICK_DIVIDER;
			settings.warn_distance   = usbz_pkg::RST_WARN_DISTANCE;
			settings.max_range       = usbz_pkg::RST_MAX_RANGE;
			settings.buzz_period_min = usbz_pkg::RST_BUZZ_PERIOD_MIN;
			settings.buzz_period_max = usbz_pkg::RST_BUZZ_PERIOD_MAX;
			tick_cnt   = '0;
			scan_sel   = 2'd1;
			armed      = 2'd1;
			half_done  = '0;
			beep_cnt   = '0;
			beep_level = 1'b0;
			for (int i = 0; i < 3; i++) begin
				echo_start[i] = '0;
				range_cm[i]   = '0;
			end
			outstanding_q.delete();
			mismatches    = 0;
			waiting       = 0;
			results_seen  = 0;
			fires_seen    = 0;
			readings_seen = 0;
		end else begin
			if (cfg_wen) begin
				case (usbz_pkg::reg_index_t'(cfg_index))
					usbz_pkg::REG_TICK_DIVIDER:    settings.tick_divider    = cfg_wdata[7:0];
					usbz_pkg::REG_WARN_DISTANCE:   settings.warn_distance   = cfg_wdata;
					usbz_pkg::REG_MAX_RANGE:       settings.max_range       = cfg_wdata;
					usbz_pkg::REG_BUZZ_PERIOD_MIN: settings.buzz_period_min = cfg_wdata[3:0];
					usbz_pkg::REG_BUZZ_PERIOD_MAX: settings.buzz_period_max = cfg_wdata[3:0];
					default: ;
				endcase
			end

			if (out_valid && out_ready) begin
				got = '{trigger, buzzer_on, dist_one, dist_two, dist_three};
				if (outstanding_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d arrived with no request outstanding", results_seen);
				end else begin
					want = outstanding_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"result %0d mismatch (expected/actual): trigger %0d/%0d",
								" buzzer %0b/%0b dist %0d/%0d %0d/%0d %0d/%0d"},
								results_seen, want.trigger, got.trigger, want.buzzer, got.buzzer,
								want.dist_one, got.dist_one, want.dist_two, got.dist_two,
								want.dist_three, got.dist_three);
					end
				end
				results_seen++;
			end

			if (in_valid && in_ready) begin
				fired = NO_TRIGGER;
				if (func) take_edge(sensor, capture);
				else fired = advance_tick();
				if (fired != NO_TRIGGER) fires_seen++;
				outstanding_q.push_back('{fired, beep_level, range_cm[0], range_cm[1], range_cm[2]});
			end

			waiting = outstanding_q.size();
		end
	end

endmodule

/* test/ultrasonic_scan_and_proximity_buzzer_core_test.sv */
// ----------------------------------------------------------------------------
// ultrasonic_scan_and_proximity_buzzer_core_test
// Drives base ticks and echo edges into the ultrasonic scan core under several
// register settings and lets a separate checker compare every result with its
// own prediction. A short directed sequence opens the run; random scan bursts
// with random idling on both handshakes follow.
// ----------------------------------------------------------------------------
module ultrasonic_scan_and_proximity_buzzer_core_test;

	localparam int CLK_HALF          = 10;
	localparam int RESET_CYCLES      = 5;
	// A slow but correct run never goes more than one long receiver hold plus
	// the longest random gap without a handshake, so this is generous.
	localparam int STALL_LIMIT       = 4000;
	localparam int LONG_HOLD         = 300;
	localparam int PRESSURE_BURST    = 40;
	localparam int DRAIN_CYCLES      = 8;
	localparam int PHASE_REQUESTS    = 150;
	localparam int RANDOM_PHASES     = 8;
	localparam int ECHO_TICKS_PER_CM = 116;

	// Request kinds carried on func.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_ECHO = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [1:0]  sensor;
	logic [15:0] capture;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  trigger;
	logic        buzzer_on;
	logic [9:0]  dist_one;
	logic [9:0]  dist_two;
	logic [9:0]  dist_three;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [usbz_pkg::CFG_DATA_W-1:0] cfg_wdata;

	int errors;
	int pending;
	int results;
	int fires;
	int readings;

	int         sent           = 0;
	int         settings_count = 0;
	int         divider_now    = usbz_pkg::RST_TICK_DIVIDER;
	// Sensor one counts as fired out of reset, so it is the first one armed.
	logic [1:0] last_fired     = 2'd1;
	// calm turns off all random idling; hold_req asks the receiver for one long
	// hold-off, and holding is high while that hold-off lasts.
	logic       calm           = 1'b0;
	logic       hold_req       = 1'b0;
	logic       holding        = 1'b0;

	ultrasonic_scan_and_proximity_buzzer_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.sensor     (sensor),
		.capture    (capture),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.trigger    (trigger),
		.buzzer_on  (buzzer_on),
		.dist_one   (dist_one),
		.dist_two   (dist_two),
		.dist_three (dist_three),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	usbz_range_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.sensor        (sensor),
		.capture       (capture),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.trigger       (trigger),
		.buzzer_on     (buzzer_on),
		.dist_one      (dist_one),
		.dist_two      (dist_two),
		.dist_three    (dist_three),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (errors),
		.waiting       (pending),
		.results_seen  (results),
		.fires_seen    (fires),
		.readings_seen (readings)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// Most requests follow with no gap or a short one; now and then a long gap lands so that
	// idle cycles fall on every stage of the two-deep pipeline.
	function automatic int idle_len();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The stimulus always resumes on a falling edge. A request stays on the
	// bus until the rising edge that accepts it; at the next falling edge the
	// following call either replaces it or lowers in_valid for a gap.
	task automatic send_request(input logic kind, input logic [1:0] src, input logic [15:0] stamp);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func     = kind;
		sensor   = src;
		capture  = stamp;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Waits until every outstanding result has come out and the pipeline has
	// had time to empty. Register writes only happen after this.
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input usbz_pkg::reg_index_t idx, input int value);
		cfg_index = idx;
		cfg_wdata = value[usbz_pkg::CFG_DATA_W-1:0];
		cfg_wen   = 1'b1;
		@(negedge clk);
	endtask

	task automatic program_registers(input int div, input int warn, input int max_cm,
		input int pmin, input int pmax);
		settle();
		write_reg(usbz_pkg::REG_TICK_DIVIDER, div);
		write_reg(usbz_pkg::REG_WARN_DISTANCE, warn);
		write_reg(usbz_pkg::REG_MAX_RANGE, max_cm);
		write_reg(usbz_pkg::REG_BUZZ_PERIOD_MIN, pmin);
		write_reg(usbz_pkg::REG_BUZZ_PERIOD_MAX, pmax);
		cfg_wen     = 1'b0;
		divider_now = div;
		settings_count++;
	endtask

	// A random run of ticks, at most one past the divider, followed most of the
	// time by an echo pair, mostly on the sensor that was just fired. The rest are stray
	// single edges and edges from random sensors, including the unused code 3.
	task automatic scan_burst();
		int          ticks;
		int          pick;
		int          cm;
		int          target;
		logic [15:0] t0;
		logic [15:0] span;
		ticks = $urandom_range(1, divider_now + 1);
		repeat (ticks) send_request(FUNC_TICK, 2'($urandom), 16'($urandom));
		target = last_fired - 2'd1;
		if ($urandom_range(0, 99) < 15) target = $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				cm = $urandom_range(0, 60);
			end else if (pick < 85) begin
				cm = $urandom_range(0, 600);
			end else begin
				cm = -1;
			end
			if (cm < 0) span = 16'($urandom);
			else span = 16'(cm * ECHO_TICKS_PER_CM + $urandom_range(0, ECHO_TICKS_PER_CM - 1));
			t0 = 16'($urandom);
			send_request(FUNC_ECHO, 2'(target), t0);
			if ($urandom_range(0, 99) < 20) send_request(FUNC_ECHO, 2'($urandom), 16'($urandom));
			send_request(FUNC_ECHO, 2'(target), t0 + span);
		end else if (pick < 90) begin
			send_request(FUNC_ECHO, 2'(target), 16'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) send_request(FUNC_ECHO, 2'($urandom), 16'($urandom));
		end
	endtask

	// Follow which sensor was fired last so that echo pairs mostly land on the
	// armed sensor and get past the first edge.
	always @(posedge clk) begin
		if (out_valid && out_ready && |trigger) last_fired <= trigger;
	end

	// Result side: random stalls between short ready windows, plus one long
	// hold-off on request that fills the core and blocks its input.
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req  = 1'b0;
				holding   = 1'b1;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holding = 1'b0;
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					out_ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// Watchdog: a run that stops moving requests or results ends as a failure.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results still outstanding",
					quiet, pending);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int base;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FUNC_TICK;
		sensor    = '0;
		capture   = '0;
		cfg_wen   = 1'b0;
		cfg_index = usbz_pkg::REG_TICK_DIVIDER;
		cfg_wdata = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings. Sensor one is armed, so a
		// start edge near the top of the timer and a stop edge after the wrap
		// give a short reading that puts the buzzer in its warning zone.
		send_request(FUNC_ECHO, 2'd0, 16'hFFF0);
		send_request(FUNC_ECHO, 2'd1, 16'h1234);   // sensor two is not armed
		send_request(FUNC_ECHO, 2'd3, 16'h5555);   // no such sensor
		send_request(FUNC_ECHO, 2'd0, 16'h0100);   // wrapped difference, 2 cm
		send_request(FUNC_ECHO, 2'd0, 16'hAAAA);   // sensor one disarmed by now
		repeat (5) send_request(FUNC_TICK, 2'd0, 16'h0000);   // fires sensor two
		send_request(FUNC_ECHO, 2'd1, 16'h0000);
		send_request(FUNC_ECHO, 2'd1, 16'hFFFF);   // beyond max range, reading kept
		repeat (3) send_request(FUNC_TICK, 2'd3, 16'hFFFF);

		// Lower the divider below the running count: the next tick must fire.
		program_registers(2, usbz_pkg::RST_WARN_DISTANCE, usbz_pkg::RST_MAX_RANGE,
			usbz_pkg::RST_BUZZ_PERIOD_MIN, usbz_pkg::RST_BUZZ_PERIOD_MAX);
		send_request(FUNC_TICK, 2'd1, 16'h8000);   // fires sensor three

		// A divider of zero fires on every tick. Sensor three is left with a
		// half-done measurement, gets fired again, and the pending start is
		// completed at exactly the 380 cm limit.
		program_registers(0, usbz_pkg::RST_WARN_DISTANCE, usbz_pkg::RST_MAX_RANGE,
			usbz_pkg::RST_BUZZ_PERIOD_MIN, usbz_pkg::RST_BUZZ_PERIOD_MAX);
		send_request(FUNC_ECHO, 2'd2, 16'h8000);
		repeat (3) send_request(FUNC_TICK, 2'd2, 16'h7FFF);
		send_request(FUNC_ECHO, 2'd2, 16'h8000 + 16'(380 * ECHO_TICKS_PER_CM));

		// Random part, one register setting per phase.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: program_registers(1, 0, 0, 1, 1);
				1: program_registers(255, 564, 564, 15, 15);
				2: program_registers(3, 1023, 1023, 15, 1);   // crossed clamps
				3: program_registers(0, 60, 380, 0, 0);       // zero period
				4: program_registers(2, 200, 300, 2, 9);
				default: program_registers($urandom_range(1, 8), $urandom_range(0, 564),
					$urandom_range(0, 564), $urandom_range(0, 15), $urandom_range(0, 15));
			endcase

			// One phase runs without any idling on either side.
			calm = (phase == 2);

			// Once, hold the result side off for a long stretch while requests
			// keep coming back to back, so the core fills and stalls its input.
			if (phase == 3) begin
				in_valid = 1'b0;
				hold_req = 1'b1;
				while (!holding) @(negedge clk);
				calm = 1'b1;
				repeat (PRESSURE_BURST) send_request(FUNC_TICK, 2'($urandom), 16'($urandom));
				calm = 1'b0;
			end

			base = sent;
			while (sent - base < PHASE_REQUESTS) scan_burst();
			calm = 1'b0;
		end

		settle();
		$display("Sent %0d requests under %0d register settings and checked %0d results.",
			sent, settings_count, results);
		$display("The core fired %0d sensors and accepted %0d range readings.", fires, readings);
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
